// ===== src/ncfr_pkg.sv =====
// Shared types, codes and the CRC-8 helper for the nibble complement frame receiver.
package ncfr_pkg;

    localparam int LINE_BUFFER_BYTES_DEF = 255;
    localparam logic [7:0] CRC_POLY = 8'h8C;

    localparam logic [7:0]  START_CODE_RST = 8'h02;
    localparam logic [7:0]  END_CODE_RST   = 8'h03;
    localparam logic [15:0] TIMEOUT_RST    = 16'd1000;

    typedef enum logic [1:0] {
        CMD_BEGIN = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_START_CODE = 2'd0,
        CFG_END_CODE   = 2'd1,
        CFG_TIMEOUT    = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_CRC   = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_TIMEOUT   = 3'd3,
        ST_RESTARTED = 3'd4,
        ST_BAD_FRAME = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0]  start_code;
        logic [7:0]  end_code;
        logic [15:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic       valid;
        logic       is_end;
        logic [7:0] payload_byte;
        t_status    status;
        logic [7:0] payload_count;
    } t_result;

    // reflected CRC-8, one byte
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            if (c[0] ^ b[i]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== src/ncfr_core.sv =====
// Frame state and single-pass request decode for the nibble complement frame receiver.
module ncfr_core
    import ncfr_pkg::*;
#(
    parameter int LINE_BUFFER_BYTES = LINE_BUFFER_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_line_byte,
    input  t_cfg       i_cfg,
    output t_result    o_res
);

    localparam logic [7:0] LINE_MAX = 8'(LINE_BUFFER_BYTES);

    logic        r_active, n_active;
    logic        r_seen_start, n_seen_start;
    logic [7:0]  r_line_count, n_line_count;
    logic [3:0]  r_held_high_nibble, n_held_high_nibble;
    logic        r_half_byte_held, n_half_byte_held;
    logic [7:0]  r_pending_byte, n_pending_byte;
    logic        r_pending_valid, n_pending_valid;
    logic [7:0]  r_running_crc, n_running_crc;
    logic [7:0]  r_emitted_count, n_emitted_count;
    logic [15:0] r_tick_count, n_tick_count;

    logic [15:0] w_limit;
    logic [15:0] w_tick_inc;
    logic        w_nibble;
    logic        w_full;
    logic [7:0]  w_emit_inc;

    assign w_limit    = (i_cfg.timeout_ticks == 16'd0) ? 16'd1 : i_cfg.timeout_ticks;
    assign w_tick_inc = (r_tick_count == 16'hFFFF) ? r_tick_count : r_tick_count + 16'd1;
    assign w_nibble   = (i_line_byte[7:4] == ~i_line_byte[3:0]);
    assign w_full     = (r_line_count >= LINE_MAX);
    assign w_emit_inc = (r_emitted_count == 8'hFF) ? r_emitted_count
                                                   : r_emitted_count + 8'd1;

    always_comb begin
        n_active           = r_active;
        n_seen_start       = r_seen_start;
        n_line_count       = r_line_count;
        n_held_high_nibble = r_held_high_nibble;
        n_half_byte_held   = r_half_byte_held;
        n_pending_byte     = r_pending_byte;
        n_pending_valid    = r_pending_valid;
        n_running_crc      = r_running_crc;
        n_emitted_count    = r_emitted_count;
        n_tick_count       = r_tick_count;
        o_res.valid         = 1'b0;
        o_res.is_end        = 1'b1;
        o_res.payload_byte  = 8'd0;
        o_res.status        = ST_OK;
        o_res.payload_count = r_emitted_count;

        if (i_fire) begin
            case (t_cmd'(i_cmd))
                CMD_BEGIN: begin
                    n_active           = 1'b1;
                    n_seen_start       = 1'b0;
                    n_tick_count       = 16'd0;
                    n_line_count       = 8'd0;
                    n_held_high_nibble = 4'd0;
                    n_half_byte_held   = 1'b0;
                    n_pending_byte     = 8'd0;
                    n_pending_valid    = 1'b0;
                    n_running_crc      = 8'd0;
                    n_emitted_count    = 8'd0;
                end
                CMD_TICK: begin
                    if (r_active) begin
                        n_tick_count = w_tick_inc;
                        if (w_tick_inc >= w_limit) begin
                            o_res.valid  = 1'b1;
                            o_res.status = ST_TIMEOUT;
                            n_active     = 1'b0;
                            n_seen_start = 1'b0;
                        end
                    end
                end
                CMD_BYTE: begin
                    if (r_active) begin
                        if (i_line_byte == i_cfg.start_code) begin
                            if (r_seen_start && w_full) begin
                                o_res.valid  = 1'b1;
                                o_res.status = ST_OVERFLOW;
                                n_active     = 1'b0;
                                n_seen_start = 1'b0;
                            end else begin
                                if (r_seen_start) begin
                                    o_res.valid  = 1'b1;
                                    o_res.status = ST_RESTARTED;
                                end
                                n_seen_start       = 1'b1;
                                n_line_count       = 8'd1;
                                n_tick_count       = 16'd0;
                                n_held_high_nibble = 4'd0;
                                n_half_byte_held   = 1'b0;
                                n_pending_byte     = 8'd0;
                                n_pending_valid    = 1'b0;
                                n_running_crc      = 8'd0;
                                n_emitted_count    = 8'd0;
                            end
                        end else if (r_seen_start) begin
                            if (w_full) begin
                                o_res.valid  = 1'b1;
                                o_res.status = ST_OVERFLOW;
                                n_active     = 1'b0;
                                n_seen_start = 1'b0;
                            end else if (i_line_byte == i_cfg.end_code) begin
                                o_res.valid  = 1'b1;
                                n_active     = 1'b0;
                                n_seen_start = 1'b0;
                                if (r_half_byte_held || !r_pending_valid) begin
                                    o_res.status = ST_BAD_FRAME;
                                end else if (r_running_crc == r_pending_byte) begin
                                    o_res.status = ST_OK;
                                end else begin
                                    o_res.status = ST_BAD_CRC;
                                end
                            end else if (w_nibble) begin
                                n_line_count = r_line_count + 8'd1;
                                if (!r_half_byte_held) begin
                                    n_held_high_nibble = i_line_byte[7:4];
                                    n_half_byte_held   = 1'b1;
                                end else begin
                                    n_half_byte_held = 1'b0;
                                    n_pending_byte   = {r_held_high_nibble, i_line_byte[7:4]};
                                    n_pending_valid  = 1'b1;
                                    if (r_pending_valid) begin
                                        n_running_crc       = crc8_update(r_running_crc,
                                                                          r_pending_byte);
                                        n_emitted_count     = w_emit_inc;
                                        o_res.valid         = 1'b1;
                                        o_res.is_end        = 1'b0;
                                        o_res.payload_byte  = r_pending_byte;
                                        o_res.payload_count = w_emit_inc;
                                    end
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active           <= 1'b0;
            r_seen_start       <= 1'b0;
            r_line_count       <= 8'd0;
            r_held_high_nibble <= 4'd0;
            r_half_byte_held   <= 1'b0;
            r_pending_byte     <= 8'd0;
            r_pending_valid    <= 1'b0;
            r_running_crc      <= 8'd0;
            r_emitted_count    <= 8'd0;
            r_tick_count       <= 16'd0;
        end else begin
            r_active           <= n_active;
            r_seen_start       <= n_seen_start;
            r_line_count       <= n_line_count;
            r_held_high_nibble <= n_held_high_nibble;
            r_half_byte_held   <= n_half_byte_held;
            r_pending_byte     <= n_pending_byte;
            r_pending_valid    <= n_pending_valid;
            r_running_crc      <= n_running_crc;
            r_emitted_count    <= n_emitted_count;
            r_tick_count       <= n_tick_count;
        end
    end

    a_res_needs_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> i_fire)
        else $error("result without a processed request");

    a_end_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.is_end && o_res.status != ST_RESTARTED) |=> !r_active)
        else $error("still active after end of reception");

    a_line_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_count <= LINE_MAX)
        else $error("line count past buffer size");

    a_payload_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.is_end) |-> (o_res.status == ST_OK &&
                                            o_res.payload_count != 8'd0 && r_pending_valid))
        else $error("malformed payload result");

endmodule

// ===== src/nibble_complement_frame_receiver.sv =====
// Top level: nibble complement frame receiver with input and result registers.
//
// Input channel: a request is i_cmd (begin, line byte, tick, nop) with i_line_byte, taken when
// i_in_valid is high and o_in_stall is low. Output channel: o_out_valid with o_is_end,
// o_payload_byte, o_status and o_payload_count, taken when i_out_stall is low.
// Each request lands in an input register; it is then decoded against the frame state
// and its result is loaded into the result register once that register may advance.
// Requests that cause no result just update state. Unless the output stalls, one request
// per cycle is sustained; the single pass of decode plus byte CRC update sets that rate.
// When the receiver stalls, the result register holds its value and the input register
// keeps its request; o_in_stall rises only while both are full and the result is blocked.
// Configuration (start code, end code, timeout ticks) is written through i_cfg_we, i_cfg_index
// and i_cfg_data, by the user only while the block is idle; the block does not enforce it.
// Synchronous reset clears the frame state, both valid flags and restores the config
// defaults: start code 0x02, end code 0x03, timeout 1000 ticks; the receiver is idle
// until a begin request.
module nibble_complement_frame_receiver
    import ncfr_pkg::*;
#(
    parameter int LINE_BUFFER_BYTES = LINE_BUFFER_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_line_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_is_end,
    output logic [7:0]  o_payload_byte,
    output logic [2:0]  o_status,
    output logic [7:0]  o_payload_count,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic [1:0] r_cmd;
    logic [7:0] r_line_byte;
    logic       r_out_valid;
    t_result    r_out;
    t_result    w_res;
    logic       w_advance;
    logic       w_fire;

    assign w_advance  = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_advance;
    assign o_in_stall = r_in_valid && !w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_code    <= START_CODE_RST;
            r_cfg.end_code      <= END_CODE_RST;
            r_cfg.timeout_ticks <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_START_CODE: r_cfg.start_code    <= i_cfg_data[7:0];
                CFG_END_CODE:   r_cfg.end_code      <= i_cfg_data[7:0];
                CFG_TIMEOUT:    r_cfg.timeout_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_cmd       <= i_cmd;
            r_line_byte <= i_line_byte;
        end
    end

    ncfr_core #(
        .LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_fire),
        .i_cmd      (r_cmd),
        .i_line_byte(r_line_byte),
        .i_cfg      (r_cfg),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_fire && w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_res.valid) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_is_end        = r_out.is_end;
    assign o_payload_byte  = r_out.payload_byte;
    assign o_status        = r_out.status;
    assign o_payload_count = r_out.payload_count;

endmodule

// ===== dv/nibble_complement_frame_receiver_test.sv =====
// Testbench for the nibble complement frame receiver: framed random traffic checked by a predictor.
`timescale 1ns / 100ps

typedef struct packed {
    logic       is_end;
    logic [7:0] payload_byte;
    logic [2:0] status;
    logic [7:0] payload_count;
} frame_result_t;

class frame_scoreboard;
    frame_result_t expected_q[$];
    int unsigned   errors;

    logic [7:0]  start_code;
    logic [7:0]  end_code;
    logic [15:0] timeout_ticks;

    bit          active;
    bit          seen_start;
    bit          half_held;
    bit          pend_valid;
    logic [7:0]  line_count;
    logic [3:0]  held_hi;
    logic [7:0]  pend_byte;
    logic [7:0]  crc;
    logic [7:0]  emitted;
    logic [15:0] ticks;

    function new();
        start_code    = 8'h02;
        end_code      = 8'h03;
        timeout_ticks = 16'd1000;
        active        = 1'b0;
        seen_start    = 1'b0;
        ticks         = '0;
        errors        = 0;
        clear_frame();
    endfunction

    // reflected CRC-8, poly 0x8C
    function logic [7:0] crc_step(input logic [7:0] c, input logic [7:0] d);
        logic [7:0] r;
        r = c ^ d;
        repeat (8) begin
            r = r[0] ? ((r >> 1) ^ 8'h8C) : (r >> 1);
        end
        return r;
    endfunction

    function void clear_frame();
        line_count = '0;
        held_hi    = '0;
        half_held  = 1'b0;
        pend_byte  = '0;
        pend_valid = 1'b0;
        crc        = '0;
        emitted    = '0;
    endfunction

    function void end_frame(input ncfr_pkg::t_status st);
        frame_result_t r;
        r.is_end        = 1'b1;
        r.payload_byte  = '0;
        r.status        = st;
        r.payload_count = emitted;
        expected_q.push_back(r);
        active     = 1'b0;
        seen_start = 1'b0;
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [15:0] d);
        case (idx)
            ncfr_pkg::CFG_START_CODE: start_code = d[7:0];
            ncfr_pkg::CFG_END_CODE:   end_code = d[7:0];
            ncfr_pkg::CFG_TIMEOUT:    timeout_ticks = d;
            default: ;
        endcase
    endfunction

    function void note_request(input logic [1:0] op, input logic [7:0] b);
        logic [15:0]   lim;
        frame_result_t r;
        if (op == ncfr_pkg::CMD_BEGIN) begin
            active     = 1'b1;
            seen_start = 1'b0;
            ticks      = '0;
            clear_frame();
            return;
        end
        if (!active || op == ncfr_pkg::CMD_NOP) return;
        if (op == ncfr_pkg::CMD_TICK) begin
            lim = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
            if (ticks != 16'hFFFF) ticks++;
            if (ticks >= lim) end_frame(ncfr_pkg::ST_TIMEOUT);
            return;
        end
        if (b == start_code) begin
            if (seen_start) begin
                if (line_count >= ncfr_pkg::LINE_BUFFER_BYTES_DEF) begin
                    end_frame(ncfr_pkg::ST_OVERFLOW);
                    return;
                end
                end_frame(ncfr_pkg::ST_RESTARTED);
                active = 1'b1;
            end
            seen_start = 1'b1;
            clear_frame();
            line_count = 8'd1;
            ticks      = '0;
            return;
        end
        if (!seen_start) return;
        if (line_count >= ncfr_pkg::LINE_BUFFER_BYTES_DEF) begin
            end_frame(ncfr_pkg::ST_OVERFLOW);
            return;
        end
        if (b == end_code) begin
            if (half_held || !pend_valid) end_frame(ncfr_pkg::ST_BAD_FRAME);
            else if (crc == pend_byte) end_frame(ncfr_pkg::ST_OK);
            else end_frame(ncfr_pkg::ST_BAD_CRC);
            return;
        end
        if (b[7:4] != ~b[3:0]) return;
        line_count++;
        if (!half_held) begin
            held_hi   = b[7:4];
            half_held = 1'b1;
            return;
        end
        half_held = 1'b0;
        // decoded bytes go out one behind; the last one is the CRC
        if (pend_valid) begin
            crc = crc_step(crc, pend_byte);
            if (emitted != 8'hFF) emitted++;
            r.is_end        = 1'b0;
            r.payload_byte  = pend_byte;
            r.status        = ncfr_pkg::ST_OK;
            r.payload_count = emitted;
            expected_q.push_back(r);
        end
        pend_byte  = {held_hi, b[7:4]};
        pend_valid = 1'b1;
    endfunction

    function void report(input string field, input logic [7:0] e, input logic [7:0] a);
        errors++;
        $display("%0t: %s expected %0h, got %0h", $time, field, e, a);
    endfunction

    function void check_result(input frame_result_t got);
        frame_result_t exp;
        if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, got end %0b byte %0h status %0d count %0d",
                     $time, got.is_end, got.payload_byte, got.status, got.payload_count);
            return;
        end
        exp = expected_q.pop_front();
        if (got.is_end !== exp.is_end) report("is_end", 8'(exp.is_end), 8'(got.is_end));
        if (got.payload_byte !== exp.payload_byte)
            report("payload_byte", exp.payload_byte, got.payload_byte);
        if (got.status !== exp.status) report("status", 8'(exp.status), 8'(got.status));
        if (got.payload_count !== exp.payload_count)
            report("payload_count", exp.payload_count, got.payload_count);
    endfunction
endclass

module nibble_complement_frame_receiver_test;
    import ncfr_pkg::*;

    localparam int unsigned ITEMS_TARGET = 1750;
    localparam int unsigned N_PHASES     = 10;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned LONG_HOLD    = 400;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd           = CMD_NOP;
    logic [7:0]  line_byte     = 8'h00;
    logic        out_valid;
    logic        out_stall     = 1'b0;
    logic        is_end;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [7:0]  payload_count;
    logic        cfg_we        = 1'b0;
    logic [1:0]  cfg_index     = CFG_START_CODE;
    logic [15:0] cfg_data      = 16'h0000;

    frame_scoreboard sb;
    int unsigned     n_sent    = 0;
    int unsigned     cycles    = 0;
    bit              burst     = 1'b0;
    bit              rx_free   = 1'b0;
    logic [7:0]      cur_start = 8'h02;
    logic [7:0]      cur_end   = 8'h03;

    nibble_complement_frame_receiver dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_cmd           (cmd),
        .i_line_byte     (line_byte),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_is_end        (is_end),
        .o_payload_byte  (payload_byte),
        .o_status        (status),
        .o_payload_count (payload_count),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_we) sb.write_reg(cfg_index, cfg_data);
            if (out_valid && !out_stall)
                sb.check_result({is_end, payload_byte, status, payload_count});
            if (in_valid && !in_stall) sb.note_request(cmd, line_byte);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("nibble_complement_frame_receiver_test: errors");
            $finish;
        end
    end

    // result side: random stalls, free-running stretches, and two long hold-offs
    initial begin : rx_side
        int unsigned n_taken;
        int unsigned hold;
        n_taken = 0;
        forever begin
            if (n_taken == 40 || n_taken == 700) hold = LONG_HOLD;
            else if (rx_free) hold = 0;
            else hold = $urandom_range(0, 15);
            if (hold != 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
            n_taken++;
            if ($urandom_range(0, 49) == 0) rx_free = !rx_free;
        end
    end

    task automatic send(input t_cmd op, input logic [7:0] value);
        int unsigned gap;
        gap = burst ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= op;
        line_byte <= value;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        n_sent++;
    endtask

    task automatic send_payload_byte(input logic [7:0] v);
        send(CMD_BYTE, {v[7:4], ~v[7:4]});
        send(CMD_BYTE, {v[3:0], ~v[3:0]});
    endtask

    task automatic write_cfg(input t_cfg_idx idx, input logic [15:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] s, input logic [7:0] e, input logic [15:0] t);
        write_cfg(CFG_START_CODE, {8'h00, s});
        write_cfg(CFG_END_CODE, {8'h00, e});
        write_cfg(CFG_TIMEOUT, t);
        cur_start = s;
        cur_end   = e;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // one frame, mostly well formed, with occasional line noise and broken pieces
    task automatic send_frame(input int unsigned n_bytes);
        logic [7:0]  fcs;
        logic [7:0]  data;
        int unsigned i;
        fcs   = '0;
        burst = ($urandom_range(0, 4) == 0);
        repeat ($urandom_range(0, 1)) send(CMD_TICK, 8'($urandom));
        if ($urandom_range(0, 9) != 0) send(CMD_BEGIN, 8'($urandom));
        repeat ($urandom_range(0, 2)) send(CMD_BYTE, 8'($urandom));
        send(CMD_BYTE, cur_start);
        for (i = 0; i < n_bytes; i++) begin
            data = (i + 1 == n_bytes && $urandom_range(0, 7) != 0) ? fcs : 8'($urandom);
            fcs  = sb.crc_step(fcs, data);
            case ($urandom_range(0, 59))
                0:       send(CMD_BYTE, 8'($urandom));
                1, 2, 3: send(CMD_TICK, 8'($urandom));
                4:       send(CMD_NOP, 8'($urandom));
                5:       send(CMD_BYTE, cur_start);
                6:       send(CMD_BYTE, {data[7:4], ~data[7:4]});
                7:       send(CMD_BEGIN, 8'($urandom));
                default: ;
            endcase
            send_payload_byte(data);
        end
        if ($urandom_range(0, 15) != 0) send(CMD_BYTE, cur_end);
    endtask

    initial begin : stimulus
        int unsigned p;
        int unsigned phase_target;
        int unsigned n;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(CMD_BYTE, 8'h02);          // idle: ignored
        send(CMD_TICK, 8'h00);
        send(CMD_NOP, 8'hFF);
        send(CMD_BEGIN, 8'hFF);
        send(CMD_BYTE, cur_end);        // end code before start: ignored
        send(CMD_BYTE, 8'hB4);          // nibble code before start: ignored
        send(CMD_BYTE, cur_start);
        send(CMD_BYTE, cur_end);        // no complete byte
        send(CMD_BEGIN, 8'h00);
        send(CMD_BYTE, cur_start);
        send(CMD_BYTE, 8'hF0);
        send(CMD_BYTE, cur_end);        // odd nibble count
        send(CMD_BEGIN, 8'h00);
        send(CMD_BYTE, cur_start);
        send_payload_byte(8'hFF);
        send(CMD_BYTE, cur_start);      // repeated start: restart result, frame begins anew
        send_payload_byte(8'h00);
        send_payload_byte(8'h00);       // CRC over one zero byte is zero
        send(CMD_BYTE, cur_end);
        send(CMD_BEGIN, 8'h00);
        send(CMD_BYTE, cur_start);
        send_payload_byte(8'hFF);
        send_payload_byte(8'h00);
        send(CMD_BYTE, cur_end);        // bad CRC

        for (p = 0; p < N_PHASES; p++) begin
            if (p != 0) begin
                wait_idle();
                case (p)
                    1: configure(8'h00, 8'hFF, 16'hFFFF);
                    2: configure(8'hFF, 8'h00, 16'd1);
                    3: configure(8'h5A, 8'h5A, 16'd3);   // start equals end, both nibble codes
                    4: configure(8'h02, 8'h69, 16'd5);   // end is a nibble code
                    default: configure(8'($urandom), 8'($urandom),
                                       16'($urandom_range(1, 12)));
                endcase
            end
            if (p == 1) send_frame(128);                 // runs past the line buffer
            phase_target = (p + 1) * ITEMS_TARGET / N_PHASES;
            while (n_sent < phase_target) begin
                if ($urandom_range(0, 119) == 0) n = $urandom_range(125, 129);
                else n = $urandom_range(0, 8);
                send_frame(n);
            end
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("nibble_complement_frame_receiver_test: clean");
        end else begin
            $display("nibble_complement_frame_receiver_test: errors");
        end
        $finish;
    end
endmodule
